// ===== src/lkt_pkg.sv =====
// Shared types and constants for the LRU key tracker.
// Used by lkt_cell and lru_key_tracker_core; no dependencies.
package lkt_pkg;

    localparam int KEY_W = 32;
    localparam int OCC_W = 4;

    typedef enum logic {
        CMD_TOUCH  = 1'b0,
        CMD_FORGET = 1'b1
    } t_cmd;

    // Contents of one list cell
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } t_entry;

    // Per-transaction control broadcast to every cell
    typedef struct packed {
        logic             load;
        logic             touch;
        logic [KEY_W-1:0] key;
    } t_ctrl;

endpackage

// ===== src/lkt_cell.sv =====
// One cell of the recency list: holds a key, compares it against the
// incoming key and shifts in from its newer neighbor. Depends on lkt_pkg.
module lkt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lkt_pkg::t_ctrl i_ctrl,
    input  logic           i_shift,      // an older cell was removed
    input  logic           i_prev_valid, // older neighbor holds a key
    input  lkt_pkg::t_entry i_next,      // newer neighbor contents
    output lkt_pkg::t_entry o_entry,
    output logic           o_hit,
    output logic           o_shift
);

    logic             r_valid;
    logic [lkt_pkg::KEY_W-1:0] r_key;
    logic             n_valid;
    logic [lkt_pkg::KEY_W-1:0] n_key;

    assign o_hit   = r_valid && (r_key == i_ctrl.key);
    assign o_shift = i_shift || o_hit;
    assign o_entry = '{valid: r_valid, key: r_key};

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        if (o_shift) begin
            if (i_next.valid) begin
                n_valid = 1'b1;
                n_key   = i_next.key;
            end else if (i_ctrl.touch && r_valid) begin
                // last held cell after the shift becomes the newest
                n_valid = 1'b1;
                n_key   = i_ctrl.key;
            end else begin
                n_valid = 1'b0;
            end
        end else if (i_ctrl.touch && !r_valid && i_prev_valid) begin
            // append into the first free cell
            n_valid = 1'b1;
            n_key   = i_ctrl.key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.load) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_key <= n_key;
        end
    end

endmodule

// ===== src/lru_key_tracker_core.sv =====
// LRU key tracker top level: a chain of lkt_cell instances plus the
// stream handshake and result register. Depends on lkt_pkg and lkt_cell.
//
// Usage:
//   Input stream (s_axis): tdata carries the 32-bit key, tuser the command
//   (0 touch, 1 forget). Output stream (m_axis): one result transaction per
//   input transaction, in order.
//   Cell 0 holds the oldest key; valid cells form an unbroken prefix.
//   A touch moves a held key to the newest cell or appends a new one,
//   evicting cell 0 when all DEPTH cells are full. A forget removes the key.
//   The result is registered and presented in the cycle after the input transaction.
//   Throughput: one transaction per cycle unless the receiver stalls. Every
//   cell compares its key in parallel and the removal point ripples up the
//   cell chain, so the whole list is updated in the accepting cycle.
//   Reset (synchronous, active low) empties the list and drops any pending
//   result. When the receiver stalls, the result register holds its value
//   and the input is held off until the result is taken; a new input is
//   accepted in the same cycle the pending result leaves.
module lru_key_tracker_core #(
    parameter int DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [31:0] key
    input  logic [0:0]  i_s_axis_tuser,  // [0] command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] was_present, [1] evicted_valid, [33:2] evicted_key,
    // [37:34] occupancy, [39:38] zero
    output logic [39:0] o_m_axis_tdata
);

    localparam int CW = $clog2(DEPTH + 1);

    lkt_pkg::t_ctrl  w_ctrl;
    lkt_pkg::t_entry w_entry [DEPTH];
    logic [DEPTH-1:0] w_hit;
    logic [DEPTH:0]   w_shift;
    logic             w_accept;
    logic             w_any_hit;
    logic             w_full;
    logic             w_evict;

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             r_out_valid;
    logic [39:0]      r_out_data;
    logic [39:0]      n_out_data;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_ctrl.load  = w_accept;
    assign w_ctrl.touch = (lkt_pkg::t_cmd'(i_s_axis_tuser[0]) == lkt_pkg::CMD_TOUCH);
    assign w_ctrl.key   = i_s_axis_tdata;

    assign w_any_hit = |w_hit;
    assign w_full    = w_entry[DEPTH-1].valid;
    assign w_evict   = w_ctrl.touch && w_full && !w_any_hit;
    assign w_shift[0] = w_evict;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            lkt_pkg::t_entry w_next;
            logic            w_prev_valid;
            if (g == DEPTH - 1) begin : g_last
                assign w_next = '{valid: 1'b0, key: '0};
            end else begin : g_mid
                assign w_next = w_entry[g+1];
            end
            if (g == 0) begin : g_first
                assign w_prev_valid = 1'b1;
            end else begin : g_rest
                assign w_prev_valid = w_entry[g-1].valid;
            end
            lkt_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_shift      (w_shift[g]),
                .i_prev_valid (w_prev_valid),
                .i_next       (w_next),
                .o_entry      (w_entry[g]),
                .o_hit        (w_hit[g]),
                .o_shift      (w_shift[g+1])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ctrl.touch) begin
            if (!w_any_hit && !w_full) begin
                n_count = r_count + CW'(1);
            end
        end else if (w_any_hit) begin
            n_count = r_count - CW'(1);
        end
        n_out_data        = '0;
        n_out_data[0]     = w_any_hit;
        n_out_data[1]     = w_evict;
        n_out_data[33:2]  = w_evict ? w_entry[0].key : '0;
        n_out_data[37:34] = lkt_pkg::OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
